// ===== rtl/core/prr_pkg.sv =====
// prr_pkg: types, constants and arithmetic helpers for the reprojection residual pipeline
// used by pinhole_reprojection_residual; no dependencies
package prr_pkg;

  localparam int NUM_FRONT  = 6;                 // input, c1 mult, t, c2 mult, pc, div setup
  localparam int DIV_BITS   = 31;                // quotient magnitude bits
  localparam int NUM_STAGES = NUM_FRONT + DIV_BITS + 3;

  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
  localparam logic signed [35:0] T_LIM   = 36'sd8589934591;
  localparam logic [30:0]        R_LIM   = 31'h7fffffff;

  // config register indexes
  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;

  typedef struct packed {
    logic [53:0] rem;
    logic [37:0] den;
    logic [30:0] quo;
    logic        neg;
    logic        ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t          lx;
    div_lane_t          ly;
    logic signed [31:0] obs_u;
    logic signed [31:0] obs_v;
    logic               dz;
  } div_stage_t;

  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] x);
    if (x > Q30_ONE) return Q30_ONE;
    if (x < -Q30_ONE) return -Q30_ONE;
    return x;
  endfunction

  // q2.30 times q16.16, kept exact
  function automatic logic signed [63:0] mul_qp(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = 64'(a);
    eb = 64'(b);
    return ea * eb;
  endfunction

  function automatic logic signed [67:0] mul_qt(input logic signed [31:0] a,
                                                input logic signed [33:0] b);
    logic signed [67:0] ea;
    logic signed [67:0] eb;
    ea = 68'(a);
    eb = 68'(b);
    return ea * eb;
  endfunction

  // round half up, drop 30 fraction bits
  function automatic logic signed [33:0] rnd_p(input logic signed [63:0] m);
    logic signed [63:0] y;
    y = m + 64'sd536870912;
    return 34'(y >>> 30);
  endfunction

  function automatic logic signed [35:0] rnd_t(input logic signed [67:0] m);
    logic signed [67:0] y;
    y = m + 68'sd536870912;
    return 36'(y >>> 30);
  endfunction

  function automatic logic signed [33:0] sat_t(input logic signed [35:0] x);
    if (x > T_LIM) return 34'(T_LIM);
    if (x < -T_LIM) return 34'(-T_LIM);
    return 34'(x);
  endfunction

  function automatic div_lane_t div_setup(input logic signed [37:0] num,
                                          input logic signed [37:0] den);
    div_lane_t   l;
    logic [37:0] na;
    logic [37:0] da;
    na = num[37] ? 38'(-num) : 38'(num);
    da = den[37] ? 38'(-den) : 38'(den);
    l.rem = {na[37:0], 16'h0000};
    l.den = da;
    l.quo = '0;
    l.neg = num[37] ^ den[37];
    // quotient would not fit in 31 bits
    l.ovf = (70'(l.rem) >= (70'(da) << DIV_BITS));
    return l;
  endfunction

  function automatic div_lane_t div_step(input div_lane_t l, input logic [4:0] b);
    div_lane_t   o;
    logic [69:0] sh;
    o  = l;
    sh = 70'(l.den) << b;
    if (70'(l.rem) >= sh) begin
      o.rem    = l.rem - sh[53:0];
      o.quo[b] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic signed [31:0] div_ratio(input div_lane_t l);
    logic [30:0] mag;
    mag = l.ovf ? R_LIM : l.quo;
    return l.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [31:0] finish(input logic signed [65:0] prod,
                                                input logic [31:0] c,
                                                input logic signed [31:0] obs);
    logic signed [65:0] y;
    logic signed [51:0] s;
    y = prod + 66'sd32768;
    s = 52'(y >>> 16) + 52'($signed({1'b0, c})) - 52'(obs);
    if (s > 52'sd2147483647) return 32'sh7fffffff;
    if (s < -52'sd2147483648) return 32'sh80000000;
    return 32'(s);
  endfunction

endpackage

// ===== rtl/core/pinhole_reprojection_residual.sv =====
// pinhole_reprojection_residual: rotate, translate and project a point, residual vs pixel
// depends on prr_pkg
// accepts one item per cycle while the output is not stalled; the pipeline is built from
// 6 arithmetic stages, a 31-stage restoring divider (one quotient bit per stage)
// and 3 scale/output stages; a full stage holds while its successor does not load
// rst_n (synchronous) clears the stage valid bits and the four camera registers
module pinhole_reprojection_residual import prr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_trans_x,
  input  logic signed [31:0] in_trans_y,
  input  logic signed [31:0] in_trans_z,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_observed_u,
  input  logic signed [31:0] in_observed_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_residual_u,
  output logic signed [31:0] out_residual_v,
  output logic               out_depth_zero,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  logic [31:0] focal_x_r, focal_y_r, center_x_r, center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= '0;
      focal_y_r  <= '0;
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x_r  <= cfg_wdata;
        REG_FOCAL_Y:  focal_y_r  <= cfg_wdata;
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage control: a stage loads when empty or when its successor loads
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // stage 1: clamp and capture
  logic signed [31:0] s1_q_r [3];
  logic signed [31:0] s1_w_r;
  logic signed [31:0] s1_p_r [3];
  logic signed [31:0] s1_tr_r [3];
  logic signed [31:0] s1_ou_r, s1_ov_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_q_r[0]  <= clamp_q(in_quat_x);
      s1_q_r[1]  <= clamp_q(in_quat_y);
      s1_q_r[2]  <= clamp_q(in_quat_z);
      s1_w_r     <= clamp_q(in_quat_w);
      s1_p_r[0]  <= in_point_x;
      s1_p_r[1]  <= in_point_y;
      s1_p_r[2]  <= in_point_z;
      s1_tr_r[0] <= in_trans_x;
      s1_tr_r[1] <= in_trans_y;
      s1_tr_r[2] <= in_trans_z;
      s1_ou_r    <= in_observed_u;
      s1_ov_r    <= in_observed_v;
    end
  end

  // stage 2: products of qv x p
  logic signed [63:0] s2_m_r [6];
  logic signed [31:0] s2_q_r [3];
  logic signed [31:0] s2_w_r;
  logic signed [31:0] s2_p_r [3];
  logic signed [31:0] s2_tr_r [3];
  logic signed [31:0] s2_ou_r, s2_ov_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_m_r[0] <= mul_qp(s1_q_r[1], s1_p_r[2]);
      s2_m_r[1] <= mul_qp(s1_q_r[2], s1_p_r[1]);
      s2_m_r[2] <= mul_qp(s1_q_r[2], s1_p_r[0]);
      s2_m_r[3] <= mul_qp(s1_q_r[0], s1_p_r[2]);
      s2_m_r[4] <= mul_qp(s1_q_r[0], s1_p_r[1]);
      s2_m_r[5] <= mul_qp(s1_q_r[1], s1_p_r[0]);
      s2_q_r    <= s1_q_r;
      s2_w_r    <= s1_w_r;
      s2_p_r    <= s1_p_r;
      s2_tr_r   <= s1_tr_r;
      s2_ou_r   <= s1_ou_r;
      s2_ov_r   <= s1_ov_r;
    end
  end

  // stage 3: t = sat(2 * (qv x p))
  logic signed [33:0] s3_t_r [3];
  logic signed [31:0] s3_q_r [3];
  logic signed [31:0] s3_w_r;
  logic signed [31:0] s3_p_r [3];
  logic signed [31:0] s3_tr_r [3];
  logic signed [31:0] s3_ou_r, s3_ov_r;
  logic signed [33:0] s3_t_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_t_nxt[i] = sat_t(36'(rnd_p(s2_m_r[2*i]) - rnd_p(s2_m_r[2*i+1])) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_t_r  <= s3_t_nxt;
      s3_q_r  <= s2_q_r;
      s3_w_r  <= s2_w_r;
      s3_p_r  <= s2_p_r;
      s3_tr_r <= s2_tr_r;
      s3_ou_r <= s2_ou_r;
      s3_ov_r <= s2_ov_r;
    end
  end

  // stage 4: products of qv x t and w * t
  logic signed [67:0] s4_m_r [6];
  logic signed [67:0] s4_wt_r [3];
  logic signed [31:0] s4_p_r [3];
  logic signed [31:0] s4_tr_r [3];
  logic signed [31:0] s4_ou_r, s4_ov_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_m_r[0] <= mul_qt(s3_q_r[1], s3_t_r[2]);
      s4_m_r[1] <= mul_qt(s3_q_r[2], s3_t_r[1]);
      s4_m_r[2] <= mul_qt(s3_q_r[2], s3_t_r[0]);
      s4_m_r[3] <= mul_qt(s3_q_r[0], s3_t_r[2]);
      s4_m_r[4] <= mul_qt(s3_q_r[0], s3_t_r[1]);
      s4_m_r[5] <= mul_qt(s3_q_r[1], s3_t_r[0]);
      for (int i = 0; i < 3; i++) begin
        s4_wt_r[i] <= mul_qt(s3_w_r, s3_t_r[i]);
      end
      s4_p_r  <= s3_p_r;
      s4_tr_r <= s3_tr_r;
      s4_ou_r <= s3_ou_r;
      s4_ov_r <= s3_ov_r;
    end
  end

  // stage 5: camera-frame point
  logic signed [37:0] s5_pc_r [3];
  logic signed [31:0] s5_ou_r, s5_ov_r;
  logic signed [37:0] s5_pc_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_pc_nxt[i] = 38'(s4_p_r[i]) + 38'(rnd_t(s4_wt_r[i]))
                   + 38'(rnd_t(s4_m_r[2*i])) - 38'(rnd_t(s4_m_r[2*i+1]))
                   + 38'(s4_tr_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_pc_r <= s5_pc_nxt;
      s5_ou_r <= s4_ou_r;
      s5_ov_r <= s4_ov_r;
    end
  end

  // stage 6 and divider: div_r[0] is the setup stage, div_r[k+1] after quotient step k
  div_stage_t div_r [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (adv[NUM_FRONT-1]) begin
      div_r[0].lx    <= div_setup(s5_pc_r[0], s5_pc_r[2]);
      div_r[0].ly    <= div_setup(s5_pc_r[1], s5_pc_r[2]);
      div_r[0].obs_u <= s5_ou_r;
      div_r[0].obs_v <= s5_ov_r;
      div_r[0].dz    <= (s5_pc_r[2] == '0);
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam logic [4:0] BIT = 5'(DIV_BITS - 1 - k);
    always_ff @(posedge clk) begin
      if (adv[NUM_FRONT+k]) begin
        div_r[k+1].lx    <= div_step(div_r[k].lx, BIT);
        div_r[k+1].ly    <= div_step(div_r[k].ly, BIT);
        div_r[k+1].obs_u <= div_r[k].obs_u;
        div_r[k+1].obs_v <= div_r[k].obs_v;
        div_r[k+1].dz    <= div_r[k].dz;
      end
    end
  end

  // ratio stage
  logic signed [31:0] rt_x_r, rt_y_r, rt_ou_r, rt_ov_r;
  logic               rt_dz_r;

  always_ff @(posedge clk) begin
    if (adv[NUM_FRONT+DIV_BITS]) begin
      rt_x_r  <= div_ratio(div_r[DIV_BITS].lx);
      rt_y_r  <= div_ratio(div_r[DIV_BITS].ly);
      rt_ou_r <= div_r[DIV_BITS].obs_u;
      rt_ov_r <= div_r[DIV_BITS].obs_v;
      rt_dz_r <= div_r[DIV_BITS].dz;
    end
  end

  // focal scale
  logic signed [65:0] fm_u_r, fm_v_r;
  logic signed [31:0] fm_ou_r, fm_ov_r;
  logic               fm_dz_r;

  always_ff @(posedge clk) begin
    if (adv[NUM_FRONT+DIV_BITS+1]) begin
      fm_u_r  <= 66'($signed({1'b0, focal_x_r})) * 66'(rt_x_r);
      fm_v_r  <= 66'($signed({1'b0, focal_y_r})) * 66'(rt_y_r);
      fm_ou_r <= rt_ou_r;
      fm_ov_r <= rt_ov_r;
      fm_dz_r <= rt_dz_r;
    end
  end

  // output register
  logic signed [31:0] res_u_r, res_v_r;
  logic               dz_r;

  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES-1]) begin
      res_u_r <= fm_dz_r ? '0 : finish(fm_u_r, center_x_r, fm_ou_r);
      res_v_r <= fm_dz_r ? '0 : finish(fm_v_r, center_y_r, fm_ov_r);
      dz_r    <= fm_dz_r;
    end
  end

  assign out_residual_u = res_u_r;
  assign out_residual_v = res_v_r;
  assign out_depth_zero = dz_r;

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth_zero |-> out_residual_u == '0 && out_residual_v == '0)
    else $error("zero depth result with nonzero residual");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output can drain");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== tb/tb_pinhole_reprojection_residual.sv =====
// tb_pinhole_reprojection_residual: self-checking bench for the reprojection residual pipeline
// predicts residuals with wide integer math, compares every output transfer in order
// depends on prr_pkg and pinhole_reprojection_residual
module tb_pinhole_reprojection_residual;
  import prr_pkg::*;

  typedef struct {
    logic signed [31:0] qx, qy, qz, qw;
    logic signed [31:0] tx, ty, tz;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] ou, ov;
  } pose_point_t;

  typedef struct {
    logic signed [31:0] ru;
    logic signed [31:0] rv;
    logic               dz;
  } residual_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_quat_x = '0, in_quat_y = '0, in_quat_z = '0, in_quat_w = '0;
  logic signed [31:0] in_trans_x = '0, in_trans_y = '0, in_trans_z = '0;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [31:0] in_observed_u = '0, in_observed_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_residual_u, out_residual_v;
  logic out_depth_zero;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  pose_point_t pending_points[$];
  residual_t   expected_residuals[$];
  logic [31:0] cam_fx, cam_fy, cam_cx, cam_cy;
  int          errors = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;

  pinhole_reprojection_residual DUT (.*);

  always #6 clk = ~clk;

  function automatic longint clamp_lim(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // round half up with floor shift
  function automatic longint rshift_round(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint qscale(longint q, longint v);
    return rshift_round(q * v, 30);
  endfunction

  function automatic longint axis_residual(longint num, longint den, logic [31:0] f,
                                           logic [31:0] c, logic signed [31:0] obs);
    longint ratio, scaled;
    ratio  = clamp_lim((num * 65536) / den, 64'sd2147483647);
    scaled = rshift_round(longint'({32'd0, f}) * ratio, 16);
    return clamp_lim(scaled + longint'({32'd0, c}) - longint'(obs), 64'sd2147483648) == 
           64'sd2147483648 ? 64'sd2147483647
         : clamp_lim(scaled + longint'({32'd0, c}) - longint'(obs), 64'sd2147483648);
  endfunction

  function automatic residual_t project_point(pose_point_t it);
    longint qv[3], p[3], tr[3], c1[3], t[3], c2[3], pc[3], w;
    residual_t r;
    qv[0] = clamp_lim(it.qx, 64'sd1073741824);
    qv[1] = clamp_lim(it.qy, 64'sd1073741824);
    qv[2] = clamp_lim(it.qz, 64'sd1073741824);
    w     = clamp_lim(it.qw, 64'sd1073741824);
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    tr[0] = it.tx; tr[1] = it.ty; tr[2] = it.tz;
    c1[0] = qscale(qv[1], p[2]) - qscale(qv[2], p[1]);
    c1[1] = qscale(qv[2], p[0]) - qscale(qv[0], p[2]);
    c1[2] = qscale(qv[0], p[1]) - qscale(qv[1], p[0]);
    for (int i = 0; i < 3; i++) t[i] = clamp_lim(2 * c1[i], 64'sd8589934591);
    c2[0] = qscale(qv[1], t[2]) - qscale(qv[2], t[1]);
    c2[1] = qscale(qv[2], t[0]) - qscale(qv[0], t[2]);
    c2[2] = qscale(qv[0], t[1]) - qscale(qv[1], t[0]);
    for (int i = 0; i < 3; i++) pc[i] = p[i] + qscale(w, t[i]) + c2[i] + tr[i];
    if (pc[2] == 0) begin
      r.ru = '0; r.rv = '0; r.dz = 1'b1;
    end else begin
      r.ru = 32'(axis_residual(pc[0], pc[2], cam_fx, cam_cx, it.ou));
      r.rv = 32'(axis_residual(pc[1], pc[2], cam_fy, cam_cy, it.ov));
      r.dz = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 32'sd1073741824;
      1: return -32'sd1073741824;
      2: return $urandom;  // may be out of range, then gets clamped
      default: return $signed($urandom_range(0, 32'h7fffffff)) - 32'sd1073741824;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_meters(bit wide);
    if (wide || $urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h01ffffff)) - 32'sd16777216;
  endfunction

  function automatic pose_point_t rand_item();
    pose_point_t it;
    bit wide;
    wide  = ($urandom_range(0, 7) == 0);
    it.qx = rand_quat(); it.qy = rand_quat(); it.qz = rand_quat(); it.qw = rand_quat();
    if ($urandom_range(0, 3) != 0) begin
      // mostly near-unit rotations so projections stay meaningful
      it.qx = $signed(it.qx) >>> 2; it.qy = $signed(it.qy) >>> 2;
      it.qz = $signed(it.qz) >>> 2; it.qw = 32'sd1000000000;
    end
    it.tx = rand_meters(wide); it.ty = rand_meters(wide); it.tz = rand_meters(wide);
    it.px = rand_meters(wide); it.py = rand_meters(wide); it.pz = rand_meters(wide);
    if ($urandom_range(0, 3) != 0) it.pz = $urandom_range(32'h00010000, 32'h01000000);
    it.ou = $urandom; it.ov = $urandom;
    if ($urandom_range(0, 19) == 0) begin
      // drive depth to exactly zero with identity rotation
      it.qx = 0; it.qy = 0; it.qz = 0; it.qw = 32'sd1073741824;
      it.tz = -it.pz;
    end
    return it;
  endfunction

  function automatic pose_point_t flat_item(logic signed [31:0] v, logic signed [31:0] qw,
                                            logic signed [31:0] pz);
    pose_point_t it;
    it.qx = 0; it.qy = 0; it.qz = 0; it.qw = qw;
    it.tx = v; it.ty = v; it.tz = 0;
    it.px = v; it.py = v; it.pz = pz;
    it.ou = v; it.ov = v;
    return it;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    case (idx)
      REG_FOCAL_X:  cam_fx = val;
      REG_FOCAL_Y:  cam_fy = val;
      REG_CENTER_X: cam_cx = val;
      REG_CENTER_Y: cam_cy = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // the last transfer may still be on the input port, so in_valid is watched too
  task automatic drain();
    do @(posedge clk);
    while (pending_points.size() != 0 || expected_residuals.size() != 0 || in_valid);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  task automatic load_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                             logic [31:0] cy);
    cfg_write(REG_FOCAL_X, fx);
    cfg_write(REG_FOCAL_Y, fy);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(3'd5, 32'hdeadbeef);  // unmapped index, must be ignored
  endtask

  // driver
  always @(posedge clk) begin
    pose_point_t it;
    if (rst_n) begin
      if (in_valid && !in_stall) void'(pending_points.pop_front());
      if ((in_valid && in_stall) ||
          ((pending_points.size() > (in_valid && !in_stall ? 0 : 0)) &&
           !in_valid && pending_points.size() > 0 && (calm || $urandom_range(0, 99) >= 11))) begin
        it = pending_points[0];
        in_valid <= 1'b1;
        in_quat_x <= it.qx; in_quat_y <= it.qy; in_quat_z <= it.qz; in_quat_w <= it.qw;
        in_trans_x <= it.tx; in_trans_y <= it.ty; in_trans_z <= it.tz;
        in_point_x <= it.px; in_point_y <= it.py; in_point_z <= it.pz;
        in_observed_u <= it.ou; in_observed_v <= it.ov;
      end else if (in_valid && !in_stall && pending_points.size() > 0 &&
                   (calm || $urandom_range(0, 99) >= 11)) begin
        it = pending_points[0];
        in_quat_x <= it.qx; in_quat_y <= it.qy; in_quat_z <= it.qz; in_quat_w <= it.qw;
        in_trans_x <= it.tx; in_trans_y <= it.ty; in_trans_z <= it.tz;
        in_point_x <= it.px; in_point_y <= it.py; in_point_z <= it.pz;
        in_observed_u <= it.ou; in_observed_v <= it.ov;
      end else if (!(in_valid && in_stall)) begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on each input transfer, check on each output transfer
  always @(posedge clk) begin
    pose_point_t it;
    residual_t exp_r;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (in_valid && !in_stall) begin
        it.qx = in_quat_x; it.qy = in_quat_y; it.qz = in_quat_z; it.qw = in_quat_w;
        it.tx = in_trans_x; it.ty = in_trans_y; it.tz = in_trans_z;
        it.px = in_point_x; it.py = in_point_y; it.pz = in_point_z;
        it.ou = in_observed_u; it.ov = in_observed_v;
        expected_residuals.push_back(project_point(it));
      end
      if (out_valid && !out_stall) begin
        if (expected_residuals.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          exp_r = expected_residuals.pop_front();
          if (out_residual_u !== exp_r.ru) begin
            $error("residual_u expected %0d got %0d", exp_r.ru, out_residual_u);
            errors++;
          end
          if (out_residual_v !== exp_r.rv) begin
            $error("residual_v expected %0d got %0d", exp_r.rv, out_residual_v);
            errors++;
          end
          if (out_depth_zero !== exp_r.dz) begin
            $error("depth_zero expected %0d got %0d", exp_r.dz, out_depth_zero);
            errors++;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 11);
    end
  end

  initial begin
    pose_point_t it;
    cam_fx = 0; cam_fy = 0; cam_cx = 0; cam_cy = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset camera is all zero: only depth flag and observations matter
    pending_points.push_back(flat_item(32'sd65536, 32'sd1073741824, 32'sd65536));
    pending_points.push_back(flat_item(32'sd0, 32'sd1073741824, 32'sd0));
    drain();

    load_camera(32'h01f40000, 32'h01f40000, 32'h01400000, 32'h00f00000);
    pending_points.push_back(flat_item(32'sh7fffffff, 32'sd1073741824, 32'sd1));
    pending_points.push_back(flat_item(32'sh80000000, -32'sd1073741824, 32'sd1));
    pending_points.push_back(flat_item(32'sd65536, 32'sd1073741824, -32'sd65536));
    pending_points.push_back(flat_item(32'sd0, 32'sd1073741824, 32'sd0));
    pending_points.push_back(flat_item(32'sd131072, 32'sh7fffffff, 32'sd65536));
    pending_points.push_back(flat_item(32'sd131072, 32'sh80000000, 32'sd65536));
    it = flat_item(32'sd65536, 32'sd0, 32'sd65536);
    it.qx = 32'sd1073741824; pending_points.push_back(it);
    it.qx = 0; it.qy = -32'sd1073741824; pending_points.push_back(it);
    it.qy = 0; it.qz = 32'sh7fffffff; pending_points.push_back(it);
    it = flat_item(32'sd65536, 32'sd759250125, 32'sh7fffffff);
    it.qx = 32'sd759250125; it.px = 32'sh80000000; pending_points.push_back(it);
    drain();

    load_camera(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    pending_points.push_back(flat_item(32'sd65536, 32'sd1073741824, 32'sd65536));
    pending_points.push_back(flat_item(-32'sd65536, 32'sd1073741824, 32'sd65536));
    pending_points.push_back(flat_item(32'sh7fffffff, 32'sd1073741824, 32'sd1));
    pending_points.push_back(flat_item(32'sh80000000, 32'sd1073741824, 32'sd1));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_camera(32'h02000000, 32'h01c00000, 32'h01400000, 32'h00f00000);
        1: load_camera(32'h0, 32'h00000001, 32'h0, 32'hffffffff);
        2: load_camera($urandom, $urandom, $urandom, $urandom);
        default: load_camera(32'h03200000, 32'h03200000, 32'h03c00000, 32'h021c0000);
      endcase
      calm = (phase == 3);
      for (int n = 0; n < 420; n++) pending_points.push_back(rand_item());
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    wait (cycle_count >= 400000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/prr_pkg.sv
rtl/core/pinhole_reprojection_residual.sv
tb/tb_pinhole_reprojection_residual.sv
